// ===== rtl/sra_pkg.sv =====
// ----------------------------------------------------------------------------
// sra_pkg: shared types and constants of the shelf rectangle allocator
// Beat payloads, status and action codes, shelf table sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package sra_pkg;

    // Shelf table sizing
    localparam int unsigned MAX_SHELVES = 64;
    localparam int unsigned SHELF_AW    = $clog2(MAX_SHELVES);
    localparam int unsigned COUNT_W     = $clog2(MAX_SHELVES + 1);

    // Page sizing
    localparam int unsigned INITIAL_PAGE_SIZE = 128;
    localparam int unsigned MAX_PAGE_SIZE     = 4096;

    // Field widths
    localparam int unsigned REQ_W   = 12;           // request width / height
    localparam int unsigned DIM_W   = 13;           // coordinates, page, shelf fields
    localparam int unsigned TOP_W   = DIM_W + 1;    // next shelf top, may pass the limit
    localparam int unsigned ENTRY_W = 3 * DIM_W;    // {top, height, fill}

    // Highest shelf top that still fits a coordinate
    localparam int unsigned TOP_LIMIT = (1 << DIM_W) - 1;

    // floor(h/10) as (h * RECIP10) >> RECIP_SH, exact for 12-bit h
    localparam int unsigned RECIP10  = 6554;
    localparam int unsigned RECIP_SH = 16;

    typedef enum logic
    {
        ACT_ALLOC = 1'b0,
        ACT_CLEAR = 1'b1
    } action_t;

    typedef enum logic [1:0]
    {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_MAX_SIZE = 2'd2
    } status_t;

    typedef struct packed
    {
        action_t            action;
        logic [REQ_W-1:0]   rect_width;
        logic [REQ_W-1:0]   rect_height;
    } req_t;

    typedef struct packed
    {
        logic [DIM_W-1:0]   pos_x;
        logic [DIM_W-1:0]   pos_y;
        logic [DIM_W-1:0]   page_width;
        logic [DIM_W-1:0]   page_height;
        logic               grew;
        status_t            status;
    } rsp_t;

    typedef struct packed
    {
        logic [DIM_W-1:0]   top;
        logic [DIM_W-1:0]   height;
        logic [DIM_W-1:0]   fill;
    } shelf_t;

endpackage

`default_nettype wire

// ===== rtl/sra_chan_if.sv =====
// ----------------------------------------------------------------------------
// sra_chan_if: request and response channels of the shelf allocator
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface sra_req_if;
    logic          valid;
    logic          ready;
    sra_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sra_rsp_if;
    logic          valid;
    logic          ready;
    sra_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/sra_ram.sv =====
// ----------------------------------------------------------------------------
// sra_ram: generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sra_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/shelf_rect_allocator.sv =====
// ----------------------------------------------------------------------------
// shelf_rect_allocator: shelf packing allocator for a growing atlas page
// Places rectangles on shelves kept in a shelf table RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one beat per item. action ALLOC places a rect_width x rect_height
//          rectangle; action CLEAR drops every shelf and returns the page to
//          its initial size.
//   rsp  : exactly one beat per request with the position, the page size after
//          the item, the grew flag and a status (ok, table full, page at max).
// Timing:
//   A clear goes straight to the result step. An allocation streams the
//   shelf table RAM one shelf per cycle (one read port, registered read
//   data) and stops at the first shelf that fits; when none fits, a new
//   shelf is opened. One item is in work at a time; req is ready again
//   once the result has moved to the rsp register.
// Reset: empty table, next shelf top 0, page at its initial size. The table
//   RAM is not cleared; only entries below the shelf count are ever read.
// Stall: the rsp register holds its beat while rsp.ready is low; the next
//   request is still taken and worked on, and its result waits until the
//   rsp register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module shelf_rect_allocator (
    input  wire logic clk,
    input  wire logic rst_n,
    sra_req_if.sink   req,
    sra_rsp_if.source rsp
);

    typedef enum logic [3:0]
    {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_NEW  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    localparam int unsigned AW  = sra_pkg::SHELF_AW;
    localparam int unsigned CW  = sra_pkg::COUNT_W;
    localparam int unsigned DW  = sra_pkg::DIM_W;
    localparam int unsigned RW  = sra_pkg::REQ_W;
    localparam int unsigned TW  = sra_pkg::TOP_W;
    localparam int unsigned PW  = RW + 14;      // width of h * RECIP10
    localparam int unsigned CPW = DW + 3;       // width of the ratio products

    // Control registers
    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [TW-1:0]     nst_reg, nst_next;
    logic [DW-1:0]     page_w_reg, page_w_next;
    logic [DW-1:0]     page_h_reg, page_h_next;
    logic [CW-1:0]     rd_idx_reg, rd_idx_next;
    logic              chk_vld_reg, chk_vld_next;
    logic              rsp_valid_reg, rsp_valid_next;

    // Payload registers
    logic [AW-1:0]     chk_idx_reg, chk_idx_next;
    logic [RW-1:0]     w_reg, w_next;
    logic [RW-1:0]     h_reg, h_next;
    logic [DW-1:0]     rh_reg, rh_next;
    sra_pkg::rsp_t     res_reg, res_next;
    sra_pkg::rsp_t     rsp_data_reg, rsp_data_next;

    // Shelf table RAM
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    sra_pkg::shelf_t   ram_wdata;
    logic [AW-1:0]     ram_raddr;
    sra_pkg::shelf_t   ram_rdata;

    // Datapath
    logic              req_fire;
    logic [PW-1:0]     h_prod;
    logic [CPW-1:0]    h_x10;
    logic [CPW-1:0]    sh_x7;
    logic [DW:0]       fill_sum;
    logic              hit;
    logic [DW+1:0]     new_bottom;
    logic              grow;
    logic              max_hit;

    sra_ram #(
        .WIDTH (sra_pkg::ENTRY_W),
        .DEPTH (sra_pkg::MAX_SHELVES)
    ) u_shelf_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // New shelf height h + floor(h/10), reciprocal multiply
    assign h_prod = PW'(req.data.rect_height) * PW'(sra_pkg::RECIP10);

    // Fit test of the shelf whose entry is on the read port
    assign h_x10    = (CPW'(h_reg) << 3) + (CPW'(h_reg) << 1);
    assign sh_x7    = (CPW'(ram_rdata.height) << 3) - CPW'(ram_rdata.height);
    assign fill_sum = (DW+1)'(ram_rdata.fill) + (DW+1)'(w_reg);
    assign hit      = chk_vld_reg
                   && (DW'(h_reg) <= ram_rdata.height)
                   && (h_x10 >= sh_x7)
                   && (fill_sum <= (DW+1)'(page_w_reg));

    // New shelf checks
    assign new_bottom = (DW+2)'(nst_reg) + (DW+2)'(rh_reg);
    assign grow       = (new_bottom >= (DW+2)'(page_h_reg))
                     || (DW'(w_reg) >= page_w_reg);
    assign max_hit    = ({page_w_reg, 1'b0} > (DW+1)'(sra_pkg::MAX_PAGE_SIZE))
                     || ({page_h_reg, 1'b0} > (DW+1)'(sra_pkg::MAX_PAGE_SIZE));

    // Next-state logic
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        nst_next       = nst_reg;
        page_w_next    = page_w_reg;
        page_h_next    = page_h_reg;
        rd_idx_next    = rd_idx_reg;
        chk_vld_next   = chk_vld_reg;
        chk_idx_next   = chk_idx_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        rh_next        = rh_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;

        ram_we    = 1'b0;
        ram_waddr = chk_idx_reg;
        ram_wdata = ram_rdata;
        ram_raddr = rd_idx_reg[AW-1:0];

        // rsp register drains on handshake
        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    w_next       = req.data.rect_width;
                    h_next       = req.data.rect_height;
                    rh_next      = DW'(req.data.rect_height)
                                 + DW'(h_prod[PW-1:sra_pkg::RECIP_SH]);
                    rd_idx_next  = '0;
                    chk_vld_next = 1'b0;
                    if (req.data.action == sra_pkg::ACT_CLEAR)
                    begin
                        count_next           = '0;
                        nst_next             = '0;
                        page_w_next          = DW'(sra_pkg::INITIAL_PAGE_SIZE);
                        page_h_next          = DW'(sra_pkg::INITIAL_PAGE_SIZE);
                        res_next.pos_x       = '0;
                        res_next.pos_y       = '0;
                        res_next.page_width  = DW'(sra_pkg::INITIAL_PAGE_SIZE);
                        res_next.page_height = DW'(sra_pkg::INITIAL_PAGE_SIZE);
                        res_next.grew        = 1'b0;
                        res_next.status      = sra_pkg::STAT_OK;
                        state_next           = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                priority if (hit)
                begin
                    // First fit: advance the fill, read-modify-write
                    ram_we               = 1'b1;
                    ram_waddr            = chk_idx_reg;
                    ram_wdata.top        = ram_rdata.top;
                    ram_wdata.height     = ram_rdata.height;
                    ram_wdata.fill       = fill_sum[DW-1:0];
                    res_next.pos_x       = ram_rdata.fill;
                    res_next.pos_y       = ram_rdata.top;
                    res_next.page_width  = page_w_reg;
                    res_next.page_height = page_h_reg;
                    res_next.grew        = 1'b0;
                    res_next.status      = sra_pkg::STAT_OK;
                    chk_vld_next         = 1'b0;
                    state_next           = ST_DONE;
                end
                else if (rd_idx_reg < count_reg)
                begin
                    // Stream the next shelf through the read port
                    chk_vld_next = 1'b1;
                    chk_idx_next = rd_idx_reg[AW-1:0];
                    rd_idx_next  = rd_idx_reg + CW'(1);
                end
                else if (chk_vld_reg)
                begin
                    chk_vld_next = 1'b0;
                end
                else
                begin
                    state_next = ST_NEW;
                end
            end

            ST_NEW:
            begin
                res_next.pos_x       = '0;
                res_next.pos_y       = '0;
                res_next.page_width  = page_w_reg;
                res_next.page_height = page_h_reg;
                res_next.grew        = 1'b0;
                state_next           = ST_DONE;
                priority if (count_reg >= CW'(sra_pkg::MAX_SHELVES))
                begin
                    res_next.status = sra_pkg::STAT_FULL;
                end
                else if (nst_reg > TW'(sra_pkg::TOP_LIMIT))
                begin
                    res_next.status = sra_pkg::STAT_MAX_SIZE;
                end
                else if (grow && max_hit)
                begin
                    res_next.status = sra_pkg::STAT_MAX_SIZE;
                end
                else
                begin
                    // Open a shelf, doubling the page first if needed
                    ram_we           = 1'b1;
                    ram_waddr        = count_reg[AW-1:0];
                    ram_wdata.top    = nst_reg[DW-1:0];
                    ram_wdata.height = rh_reg;
                    ram_wdata.fill   = DW'(w_reg);
                    count_next       = count_reg + CW'(1);
                    nst_next         = new_bottom[TW-1:0];
                    if (grow)
                    begin
                        page_w_next = {page_w_reg[DW-2:0], 1'b0};
                        page_h_next = {page_h_reg[DW-2:0], 1'b0};
                    end
                    res_next.pos_y       = nst_reg[DW-1:0];
                    res_next.page_width  = grow ? {page_w_reg[DW-2:0], 1'b0} : page_w_reg;
                    res_next.page_height = grow ? {page_h_reg[DW-2:0], 1'b0} : page_h_reg;
                    res_next.grew        = grow;
                    res_next.status      = sra_pkg::STAT_OK;
                end
            end

            ST_DONE:
            begin
                // Hand the result to the rsp register once it is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            nst_reg       <= '0;
            page_w_reg    <= DW'(sra_pkg::INITIAL_PAGE_SIZE);
            page_h_reg    <= DW'(sra_pkg::INITIAL_PAGE_SIZE);
            rd_idx_reg    <= '0;
            chk_vld_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            nst_reg       <= nst_next;
            page_w_reg    <= page_w_next;
            page_h_reg    <= page_h_next;
            rd_idx_reg    <= rd_idx_next;
            chk_vld_reg   <= chk_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        chk_idx_reg  <= chk_idx_next;
        w_reg        <= w_next;
        h_reg        <= h_next;
        rh_reg       <= rh_next;
        res_reg      <= res_next;
        rsp_data_reg <= rsp_data_next;
    end

    // Assertions
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(sra_pkg::MAX_SHELVES))
        else $error("shelf count beyond table depth");

    a_square_page: assert property (@(posedge clk) disable iff (!rst_n)
        page_w_reg == page_h_reg)
        else $error("page lost its square shape");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (req.data.action == sra_pkg::ACT_CLEAR)) |=>
            (count_reg == '0) && (nst_reg == '0))
        else $error("clear did not empty the shelf table");

    a_write_once: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> (state_reg == ST_DONE) && !ram_we)
        else $error("table written outside the final step of an item");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        chk_vld_reg |-> (CW'(chk_idx_reg) < count_reg))
        else $error("scan checked an entry beyond the shelf count");

endmodule

`default_nettype wire
